// ===== hw/rtl/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the multicore task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package mts_pkg;
    localparam int CORES_DEF         = 4;
    localparam int TASK_SLOTS_DEF    = 16;
    localparam int PRIORITY_BITS_DEF = 3;
    localparam int RUNTIME_BITS_DEF  = 32;

    localparam logic OP_ENQ  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_CORE  = 2'd1;
    localparam logic [1:0] ST_OCCUPIED = 2'd2;

    localparam logic [4:0] NO_TASK = 5'd16;

    typedef struct packed {
        logic       opcode;
        logic [3:0] task_slot;
        logic [2:0] task_priority;
        logic       task_runnable;
        logic [3:0] allowed_cores;
        logic [1:0] tick_core;
        logic       preempt_ok;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] chosen_core;
        logic       switched;
        logic [4:0] next_task;
        logic       migrated;
        logic [1:0] migrate_target;
    } t_rsp;
endpackage
`default_nettype wire

// ===== hw/rtl/mts_if.sv =====
// ----------------------------------------------------------------------------
// mts_req_if / mts_rsp_if
// Valid/ready channels carrying requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none
interface mts_req_if;
    logic          valid;
    logic          ready;
    mts_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mts_rsp_if;
    logic          valid;
    logic          ready;
    mts_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mts_slot_mem.sv =====
// ----------------------------------------------------------------------------
// mts_slot_mem
// Task slot memory: one synchronous port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module mts_slot_mem #(
    parameter int AW = 4,
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [DW-1:0] i_wdata,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/multicore_task_scheduler.sv =====
// Enqueue: S_EWR writes the slot, then S_RSP offers the response.
// Tick: S_RCUR, then S_WCUR; a reschedule adds S_SCAN, S_RNXT, S_WNXT, S_MIG,
// the scan reading one slot per cycle through the single memory port.
// One request at a time; the next is taken the cycle after the response.
// Synchronous active-low reset clears valid bits, weights and current tasks.
// ----------------------------------------------------------------------------
// multicore_task_scheduler
// Load-balancing run-queue scheduler with slot state in a memory.
// ----------------------------------------------------------------------------
`default_nettype none
module multicore_task_scheduler #(
    parameter int RUNTIME_BITS  = mts_pkg::RUNTIME_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mts_req_if.sink   i_req,
    mts_rsp_if.source o_rsp
);
    localparam int CORES         = mts_pkg::CORES_DEF;
    localparam int TASK_SLOTS    = mts_pkg::TASK_SLOTS_DEF;
    localparam int PRIORITY_BITS = mts_pkg::PRIORITY_BITS_DEF;
    localparam int SW  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int NC  = (CORES < 4) ? CORES : 4;
    localparam int WW  = 12;
    localparam int CDW = 8;
    // entry: runnable, priority, mask, home, runtime, countdown
    localparam int DW  = 1 + 3 + 4 + 2 + RUNTIME_BITS + CDW;

    typedef struct packed {
        logic                    runnable;
        logic [2:0]              pri;
        logic [3:0]              mask;
        logic [1:0]              home;
        logic [RUNTIME_BITS-1:0] runtime;
        logic [CDW-1:0]          cnt;
    } t_ent;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EWR   = 9'b000000010,
        S_RCUR  = 9'b000000100,
        S_WCUR  = 9'b000001000,
        S_SCAN  = 9'b000010000,
        S_RNXT  = 9'b000100000,
        S_WNXT  = 9'b001000000,
        S_MIG   = 9'b010000000,
        S_RSP   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    mts_pkg::t_req r_req;
    mts_pkg::t_rsp r_rsp;
    logic [TASK_SLOTS-1:0] r_valid;
    logic [WW-1:0]  r_weight [4];
    logic [4:0]     r_cur [4];
    logic [3:0]     r_idle_cnt;
    logic [31:0]    r_sw_total [4];
    logic [SW:0]    r_scan;
    logic           r_scan_pend;
    logic [SW-1:0]  r_scan_addr;
    logic           r_found;
    logic [SW-1:0]  r_best;
    logic [RUNTIME_BITS-1:0] r_best_key;
    t_ent           r_cur_ent;
    logic           r_cur_task;

    logic           mem_we;
    logic [SW-1:0]  mem_addr;
    t_ent           mem_wdata, mem_rdata;

    mts_slot_mem #(.AW(SW), .DW(DW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    logic [1:0] core;
    logic [4:0] cur;
    logic       cur_task_c;
    assign core       = r_req.tick_core;
    assign cur        = r_cur[core];
    assign cur_task_c = ({27'd0, cur} < TASK_SLOTS) && r_valid[cur[SW-1:0]];

    // least-weight allowed core below limit
    function automatic logic [2:0] pick(input logic [3:0] m, input logic [WW:0] lim,
                                        input logic [WW-1:0] w0, input logic [WW-1:0] w1,
                                        input logic [WW-1:0] w2, input logic [WW-1:0] w3);
        logic [WW:0] mn;
        logic [2:0] b;
        logic [WW-1:0] w [4];
        mn = lim;
        b = 3'b100;
        w[0] = w0; w[1] = w1; w[2] = w2; w[3] = w3;
        for (int c = 0; c < NC; c++) begin
            if (m[c] && ({1'b0, w[c]} < mn)) begin
                b = {1'b0, 2'(c)};
                mn = {1'b0, w[c]};
            end
        end
        return b;
    endfunction

    logic [2:0] enq_pick;
    assign enq_pick = pick(r_req.allowed_cores, {(WW+1){1'b1}},
                           r_weight[0], r_weight[1], r_weight[2], r_weight[3]);

    logic [WW-1:0] share;
    logic [2:0]    mig_pick;
    assign share = WW'(1) << r_cur_ent.pri;
    assign mig_pick = (r_weight[core] >= share)
        ? pick(r_cur_ent.mask, {1'b0, r_weight[core] - share},
               r_weight[0], r_weight[1], r_weight[2], r_weight[3])
        : 3'b100;

    logic [RUNTIME_BITS-1:0] key;
    logic          scan_hit;
    assign key = mem_rdata.runtime >> mem_rdata.pri;
    assign scan_hit = r_scan_pend && r_valid[r_scan_addr] && mem_rdata.runnable &&
                      (mem_rdata.home == core);

    logic [SW-1:0] nxt_slot;
    assign nxt_slot = r_best;

    logic [4:0] nxt_code;
    assign nxt_code = r_found ? 5'(nxt_slot) : mts_pkg::NO_TASK;

    logic zero_c;
    assign zero_c = cur_task_c ? (mem_rdata.cnt <= CDW'(1)) : 1'b1;

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_addr  = r_req.task_slot[SW-1:0];
        mem_wdata = mem_rdata;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = (i_req.data.opcode == mts_pkg::OP_ENQ) ? S_EWR : S_RCUR;
                end
            end
            S_EWR: begin
                n_state = S_RSP;
                mem_wdata.runnable = r_req.task_runnable;
                mem_wdata.pri      = 3'(r_req.task_priority & 3'((1 << PRIORITY_BITS) - 1));
                mem_wdata.mask     = r_req.allowed_cores;
                mem_wdata.home     = enq_pick[1:0];
                mem_wdata.runtime  = '0;
                mem_wdata.cnt      = '0;
                mem_we = !enq_pick[2] && ({28'd0, r_req.task_slot} < TASK_SLOTS) &&
                         !r_valid[r_req.task_slot[SW-1:0]];
            end
            S_RCUR: begin
                mem_addr = cur[SW-1:0];
                n_state = ({30'd0, core} >= CORES) ? S_RSP : S_WCUR;
            end
            S_WCUR: begin
                mem_addr = cur[SW-1:0];
                mem_we = cur_task_c;
                mem_wdata.runtime = mem_rdata.runtime + RUNTIME_BITS'(1);
                mem_wdata.cnt = (mem_rdata.cnt != '0) ? mem_rdata.cnt - CDW'(1) : '0;
                n_state = (r_req.preempt_ok && zero_c) ? S_SCAN : S_RSP;
            end
            S_SCAN: begin
                mem_addr = r_scan[SW-1:0];
                if (!r_scan_pend && r_scan == (SW+1)'(TASK_SLOTS)) begin
                    n_state = S_RNXT;
                end
            end
            S_RNXT: begin
                mem_addr = nxt_slot;
                n_state = S_WNXT;
            end
            S_WNXT: begin
                mem_addr = nxt_slot;
                mem_we = r_found;
                mem_wdata.cnt = CDW'(1) << mem_rdata.pri;
                n_state = S_MIG;
            end
            S_MIG: begin
                mem_addr = cur[SW-1:0];
                mem_wdata = r_cur_ent;
                mem_wdata.home = mig_pick[1:0];
                mem_we = r_cur_task && !mig_pick[2] && (cur != nxt_code);
                n_state = S_RSP;
            end
            S_RSP: begin
                if (o_rsp.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_RSP);
    assign o_rsp.data  = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_idle_cnt <= '0;
            for (int c = 0; c < 4; c++) begin
                r_weight[c]   <= '0;
                r_cur[c]      <= mts_pkg::NO_TASK;
                r_sw_total[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req <= i_req.data;
                        r_rsp <= '0;
                    end
                end
                S_EWR: begin
                    if (enq_pick[2]) begin
                        r_rsp.status <= mts_pkg::ST_NO_CORE;
                    end else if (!mem_we) begin
                        r_rsp.status <= mts_pkg::ST_OCCUPIED;
                    end else begin
                        r_valid[r_req.task_slot[SW-1:0]] <= 1'b1;
                        r_weight[enq_pick[1:0]] <= r_weight[enq_pick[1:0]] +
                            (WW'(1) << mem_wdata.pri);
                        r_rsp.chosen_core <= enq_pick[1:0];
                    end
                end
                S_RCUR: begin
                    r_rsp.next_task <= ({30'd0, core} >= CORES) ? mts_pkg::NO_TASK : cur;
                end
                S_WCUR: begin
                    r_cur_task <= cur_task_c;
                    r_cur_ent  <= mem_wdata;
                    if (!cur_task_c) r_idle_cnt[core] <= 1'b0;
                    r_scan      <= '0;
                    r_scan_pend <= 1'b0;
                    r_found     <= 1'b0;
                    r_best      <= '0;
                    r_best_key  <= '0;
                end
                S_SCAN: begin
                    if (scan_hit && (!r_found || key < r_best_key)) begin
                        r_found    <= 1'b1;
                        r_best     <= r_scan_addr;
                        r_best_key <= key;
                    end
                    r_scan_pend <= (r_scan != (SW+1)'(TASK_SLOTS));
                    r_scan_addr <= r_scan[SW-1:0];
                    if (r_scan != (SW+1)'(TASK_SLOTS)) r_scan <= r_scan + 1'b1;
                end
                S_WNXT: begin
                    if (!r_found) r_idle_cnt[core] <= 1'b1;
                end
                S_MIG: begin
                    if (cur != nxt_code) begin
                        r_rsp.switched  <= 1'b1;
                        r_rsp.next_task <= nxt_code;
                        r_cur[core]     <= nxt_code;
                        r_sw_total[core] <= r_sw_total[core] + 32'd1;
                        if (mem_we) begin
                            r_weight[core] <= r_weight[core] - share;
                            r_weight[mig_pick[1:0]] <= r_weight[mig_pick[1:0]] + share;
                            r_rsp.migrated <= 1'b1;
                            r_rsp.migrate_target <= mig_pick[1:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/mts_checker.sv =====
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks on the scheduler's request and response channels.
// ----------------------------------------------------------------------------
`default_nettype none
module mts_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_ready,
    input wire logic          i_out_valid,
    input wire logic          i_out_ready,
    input wire mts_pkg::t_rsp i_out_data
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid)) else $error("ready during response");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("response dropped");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.status != 2'd3) else $error("bad status");
    a_mig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.migrated |-> i_out_data.switched)
        else $error("migrate without switch");
endmodule

bind multicore_task_scheduler mts_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_ready(i_req.ready),
    .i_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready), .i_out_data(o_rsp.data)
);
`default_nettype wire

// ===== tb/multicore_task_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multicore_task_scheduler_tb
// Drives enqueue and tick requests through the request channel, predicts each
// response with its own behavioural scheduler or a fixed table row, and compares
// every field. A directed table comes first, then random traffic with random gaps.
// ----------------------------------------------------------------------------
`default_nettype none
module multicore_task_scheduler_tb;
    localparam int NCORE = 4;
    localparam int NSLOT = 16;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mts_req_if req_ch ();
    mts_rsp_if rsp_ch ();

    multicore_task_scheduler u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // scheduler shadow state
    bit          sv_valid   [NSLOT];
    bit          sv_run     [NSLOT];
    logic [2:0]  sv_pri     [NSLOT];
    logic [3:0]  sv_mask    [NSLOT];
    logic [1:0]  sv_home    [NSLOT];
    logic [31:0] sv_runtime [NSLOT];
    logic [7:0]  sv_cdown   [NSLOT];
    logic [11:0] cw         [NCORE];
    logic [4:0]  cur_task   [NCORE];
    bit          idle_cd    [NCORE];

    mts_pkg::t_rsp rsp_due[$];
    int   errors = 0;
    mts_pkg::t_rsp directed_rsp;
    bit   directed_has;

    function automatic int least_core(logic [3:0] mask, longint limit);
        int best = -1;
        longint lo = limit;
        for (int c = 0; c < NCORE; c++)
            if (mask[c] && longint'(cw[c]) < lo) begin
                best = c;
                lo = cw[c];
            end
        return best;
    endfunction

    function automatic mts_pkg::t_rsp schedule(mts_pkg::t_req r);
        mts_pkg::t_rsp o = '0;
        int c, core, nxt, t;
        logic [4:0] cur;
        bit on_task, hit_zero;
        logic [31:0] key, bestkey;
        logic [11:0] share;
        if (r.opcode == mts_pkg::OP_ENQ) begin
            c = least_core(r.allowed_cores, 64'h7fff_ffff_ffff_ffff);
            if (c < 0) o.status = mts_pkg::ST_NO_CORE;
            else if (sv_valid[r.task_slot]) o.status = mts_pkg::ST_OCCUPIED;
            else begin
                sv_valid[r.task_slot]   = 1'b1;
                sv_run[r.task_slot]     = r.task_runnable;
                sv_pri[r.task_slot]     = r.task_priority;
                sv_mask[r.task_slot]    = r.allowed_cores;
                sv_home[r.task_slot]    = c[1:0];
                sv_runtime[r.task_slot] = '0;
                sv_cdown[r.task_slot]   = '0;
                cw[c] += 12'(1) << r.task_priority;
                o.chosen_core = c[1:0];
            end
        end else begin
            core = r.tick_core;
            cur = cur_task[core];
            on_task = cur < NSLOT && sv_valid[cur[3:0]];
            if (on_task) begin
                sv_runtime[cur[3:0]] += 32'd1;
                if (sv_cdown[cur[3:0]] > 0) sv_cdown[cur[3:0]] -= 8'd1;
                hit_zero = sv_cdown[cur[3:0]] == 0;
            end else begin
                idle_cd[core] = 1'b0;
                hit_zero = 1'b1;
            end
            if (r.preempt_ok && hit_zero) begin
                nxt = mts_pkg::NO_TASK;
                bestkey = '0;
                for (int s = 0; s < NSLOT; s++)
                    if (sv_valid[s] && sv_run[s] && sv_home[s] == core) begin
                        key = sv_runtime[s] >> sv_pri[s];
                        if (nxt == mts_pkg::NO_TASK || key < bestkey) begin
                            nxt = s;
                            bestkey = key;
                        end
                    end
                if (nxt == mts_pkg::NO_TASK) idle_cd[core] = 1'b1;
                else sv_cdown[nxt] = 8'(1) << sv_pri[nxt];
                if (nxt != cur) begin
                    o.switched = 1'b1;
                    cur_task[core] = nxt[4:0];
                    if (on_task) begin
                        share = 12'(1) << sv_pri[cur[3:0]];
                        if (cw[core] >= share) begin
                            t = least_core(sv_mask[cur[3:0]], longint'(cw[core] - share));
                            if (t >= 0) begin
                                cw[core] -= share;
                                cw[t] += share;
                                sv_home[cur[3:0]] = t[1:0];
                                o.migrated = 1'b1;
                                o.migrate_target = t[1:0];
                            end
                        end
                    end
                end
            end
            o.next_task = cur_task[core];
        end
        return o;
    endfunction

    task automatic send_request(mts_pkg::t_req r);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        // valid is dropped at the accepting edge, so raise it at a later one
        repeat (gap + 1) @(posedge i_clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        req_ch.valid <= 1'b0;
        rsp_due.push_back(schedule(r));
        if (directed_has) rsp_due[$] = directed_rsp;
    endtask

    // response sink with random stalls
    initial begin
        int hold;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0) hold = 0;
            if (hold != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        mts_pkg::t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_due.size() == 0) begin
                $display("%0t: unexpected response %p", $time, rsp_ch.data);
                errors++;
            end else begin
                want = rsp_due.pop_front();
                if (want !== rsp_ch.data) begin
                    $display("%0t: response mismatch expected %p actual %p",
                             $time, want, rsp_ch.data);
                    errors++;
                end
            end
        end
    end

    function automatic mts_pkg::t_req mk(logic op, int slot, int pri, int run, int mask,
                                         int core, int pok);
        mts_pkg::t_req r;
        r.opcode = op;
        r.task_slot = slot[3:0];
        r.task_priority = pri[2:0];
        r.task_runnable = run[0];
        r.allowed_cores = mask[3:0];
        r.tick_core = core[1:0];
        r.preempt_ok = pok[0];
        return r;
    endfunction

    typedef struct {
        mts_pkg::t_req r;
        bit            fixed;
        mts_pkg::t_rsp rsp;
    } t_row;

    function automatic mts_pkg::t_rsp tick_rsp(int nt);
        mts_pkg::t_rsp o = '0;
        o.next_task = nt[4:0];
        return o;
    endfunction

    function automatic mts_pkg::t_rsp enq_rsp(logic [1:0] st, int core);
        mts_pkg::t_rsp o = '0;
        o.status = st;
        o.chosen_core = core[1:0];
        return o;
    endfunction

    initial begin
        t_row rows[$];
        mts_pkg::t_req r;
        int n;
        for (int s = 0; s < NSLOT; s++) sv_valid[s] = 1'b0;
        for (int c = 0; c < NCORE; c++) begin
            cw[c] = '0;
            cur_task[c] = mts_pkg::NO_TASK;
            idle_cd[c] = 1'b0;
        end
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        directed_has = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back('{mk(mts_pkg::OP_TICK, 0, 0, 0, 0, 0, 1), 1,
                         tick_rsp(mts_pkg::NO_TASK)});
        rows.push_back('{mk(mts_pkg::OP_TICK, 15, 7, 1, 15, 3, 0), 1,
                         tick_rsp(mts_pkg::NO_TASK)});
        rows.push_back('{mk(mts_pkg::OP_ENQ, 3, 2, 1, 0, 0, 0), 1,
                         enq_rsp(mts_pkg::ST_NO_CORE, 0)});
        rows.push_back('{mk(mts_pkg::OP_ENQ, 0, 7, 1, 15, 0, 0), 1,
                         enq_rsp(mts_pkg::ST_OK, 0)});
        rows.push_back('{mk(mts_pkg::OP_ENQ, 0, 1, 1, 15, 0, 0), 1,
                         enq_rsp(mts_pkg::ST_OCCUPIED, 0)});
        rows.push_back('{mk(mts_pkg::OP_ENQ, 15, 0, 1, 15, 0, 0), 1,
                         enq_rsp(mts_pkg::ST_OK, 1)});
        rows.push_back('{mk(mts_pkg::OP_ENQ, 1, 0, 0, 4'b1000, 0, 0), 1,
                         enq_rsp(mts_pkg::ST_OK, 3)});
        rows.push_back('{mk(mts_pkg::OP_ENQ, 2, 3, 1, 4'b0001, 0, 0), 0, '0});
        rows.push_back('{mk(mts_pkg::OP_ENQ, 4, 0, 1, 4'b0101, 0, 0), 0, '0});
        for (int i = 0; i < 12; i++)
            rows.push_back('{mk(mts_pkg::OP_TICK, 0, 0, 0, 0, i % 4, (i % 3) != 1), 0, '0});
        for (int i = 0; i < rows.size(); i++) begin
            directed_has = rows[i].fixed;
            directed_rsp = rows[i].rsp;
            send_request(rows[i].r);
        end
        directed_has = 1'b0;

        n = 0;
        while (n < 900) begin
            if (n == 450) wait (rsp_due.size() == 0);
            r = mk($urandom_range(0, 9) < 3 ? mts_pkg::OP_ENQ : mts_pkg::OP_TICK,
                   $urandom_range(0, 15),
                   $urandom_range(0, 7), $urandom_range(0, 5) != 0,
                   $urandom_range(0, 20) == 0 ? 0 : $urandom_range(1, 15),
                   $urandom_range(0, 3), $urandom_range(0, 3) != 0);
            send_request(r);
            n++;
        end
        wait (rsp_due.size() == 0);
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("multicore_task_scheduler regression: pass");
        else
            $display("multicore_task_scheduler regression: fail");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("multicore_task_scheduler regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/mts_pkg.sv
hw/rtl/mts_if.sv
hw/rtl/mts_slot_mem.sv
hw/rtl/multicore_task_scheduler.sv
hw/rtl/mts_checker.sv
tb/multicore_task_scheduler_tb.sv
